// ----- src/dual_sensor_report_on_change_assert.svh -----
// assertion macros for the dual sensor report-on-change block
// needs clk and rst in scope where a macro is used
`ifndef DUAL_SENSOR_REPORT_ON_CHANGE_ASSERT_SVH
`define DUAL_SENSOR_REPORT_ON_CHANGE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dsr_pkg.sv -----
// shared types and constants for the dual sensor report-on-change block
// no dependencies
package dsr_pkg;

  localparam int TEMP_W       = 15;
  localparam int TICK_W       = 32;
  localparam int THR_W        = 15;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [THR_W-1:0]  THR_RESET = 15'd100;
  localparam logic [TICK_W-1:0] HB_RESET  = 32'd60000;

  // register select is address bit 2
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_HEARTBEAT = 1'b1;

  // input tdata field positions
  localparam int IN_TICK_LSB   = 0;
  localparam int IN_LINK_BIT   = 32;
  localparam int IN_VALIDA_BIT = 33;
  localparam int IN_TEMPA_LSB  = 34;
  localparam int IN_VALIDB_BIT = 49;
  localparam int IN_TEMPB_LSB  = 50;

  // output tdata field positions
  localparam int OUT_REPA_BIT  = 0;
  localparam int OUT_RSNA_LSB  = 1;
  localparam int OUT_VALA_LSB  = 4;
  localparam int OUT_REPB_BIT  = 19;
  localparam int OUT_RSNB_LSB  = 20;
  localparam int OUT_VALB_LSB  = 23;

  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_CHANGED  = 3'd1,
    RSN_INITIAL  = 3'd2,
    RSN_PERIODIC = 3'd3,
    RSN_PEER     = 3'd4
  } reason_t;

endpackage

// ----- src/dual_sensor_report_on_change.sv -----
// top level of the dual sensor report-on-change block
// depends on dsr_pkg
//
// usage
//   s_* channel: one sampling round per transfer (tick, link flag, and a valid
//   flag and centidegree reading for each of sensors a and b)
//   m_* channel: one result per round (report flag, reason and value for each
//   channel); every round gives exactly one result
//   apb port: delta_threshold at 0x0, heartbeat_ticks at 0x4, write only while
//   idle; reads return the current register value, pready is tied high
// timing
//   a round is held in the input register and judged there; its
//   result lands in the output register, so m_tvalid rises when the round
//   leaves the input register, which waits while a held result is not taken
//   throughput is one round per cycle while m_tready stays high: the judging
//   logic is one short compare-and-update per channel, and the per-channel
//   history it updates is ready for the following round on the next edge
// reset
//   both pipeline stages empty, both channels marked as never reported,
//   registers back to threshold 100 and heartbeat 60000
// stall
//   while m_tready is low the result holds; the input register still takes one
//   more round and then s_tready drops until the result is taken
module dual_sensor_report_on_change (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // now_tick[31:0], link_up[32], valid_a[33], temp_a[48:34], valid_b[49],
  // temp_b[64:50], zero pad [71:65]
  input  logic [dsr_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // report_a[0], reason_a[3:1], value_a[18:4], report_b[19], reason_b[22:20],
  // value_b[37:23], zero pad [39:38]
  output logic [dsr_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dsr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dsr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import dsr_pkg::*;

  // configuration registers
  logic [THR_W-1:0]  delta_threshold;
  logic [TICK_W-1:0] heartbeat_ticks;

  // input register (stage 1)
  logic              s1_valid;
  logic [TICK_W-1:0] in_tick;
  logic              in_link;
  logic              in_valid_a;
  logic [TEMP_W-1:0] in_temp_a;
  logic              in_valid_b;
  logic [TEMP_W-1:0] in_temp_b;

  // per-channel history
  logic              reported_a;
  logic [TEMP_W-1:0] last_value_a;
  logic [TICK_W-1:0] last_tick_a;
  logic              reported_b;
  logic [TEMP_W-1:0] last_value_b;
  logic [TICK_W-1:0] last_tick_b;

  // result register (stage 2)
  logic              out_valid;
  reason_t           rsn_a;
  reason_t           rsn_b;
  logic [TEMP_W-1:0] val_a;
  logic [TEMP_W-1:0] val_b;

  logic              s1_adv;
  logic              able_a;
  logic              able_b;
  reason_t           own_a;
  reason_t           own_b;
  reason_t           rsn_a_next;
  reason_t           rsn_b_next;
  logic              wr_en;

  // own reason of one channel: initial, then changed, then periodic
  function automatic reason_t chan_reason(
    input logic              able,
    input logic              reported,
    input logic [TEMP_W-1:0] temp,
    input logic [TEMP_W-1:0] last_value,
    input logic [TICK_W-1:0] now,
    input logic [TICK_W-1:0] last_tick,
    input logic [THR_W-1:0]  thr,
    input logic [TICK_W-1:0] hb
  );
    logic [TEMP_W:0]   diff;
    logic [TEMP_W:0]   mag;
    logic [TICK_W-1:0] elapsed;
    reason_t           rsn;
    diff    = {temp[TEMP_W-1], temp} - {last_value[TEMP_W-1], last_value};
    mag     = diff[TEMP_W] ? (~diff + 1'b1) : diff;
    elapsed = now - last_tick;  // wraps modulo 2^32
    if (!able) begin
      rsn = RSN_NONE;
    end else if (!reported) begin
      rsn = RSN_INITIAL;
    end else if (mag >= {1'b0, thr}) begin
      rsn = RSN_CHANGED;
    end else if (elapsed >= hb) begin
      rsn = RSN_PERIODIC;
    end else begin
      rsn = RSN_NONE;
    end
    return rsn;
  endfunction

  // pipeline flow: stage 1 moves on when the result register is free or drains
  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick    <= s_tdata[IN_TICK_LSB +: TICK_W];
      in_link    <= s_tdata[IN_LINK_BIT];
      in_valid_a <= s_tdata[IN_VALIDA_BIT];
      in_temp_a  <= s_tdata[IN_TEMPA_LSB +: TEMP_W];
      in_valid_b <= s_tdata[IN_VALIDB_BIT];
      in_temp_b  <= s_tdata[IN_TEMPB_LSB +: TEMP_W];
    end
  end

  // judging logic on the registered round
  always_comb begin
    able_a = in_link && in_valid_a;
    able_b = in_link && in_valid_b;
    own_a  = chan_reason(able_a, reported_a, in_temp_a, last_value_a, in_tick,
                         last_tick_a, delta_threshold, heartbeat_ticks);
    own_b  = chan_reason(able_b, reported_b, in_temp_b, last_value_b, in_tick,
                         last_tick_b, delta_threshold, heartbeat_ticks);
    // peer sync: an able but quiet channel follows a channel with its own reason
    rsn_a_next = own_a;
    rsn_b_next = own_b;
    if (able_a && (own_a == RSN_NONE) && (own_b != RSN_NONE)) begin
      rsn_a_next = RSN_PEER;
    end
    if (able_b && (own_b == RSN_NONE) && (own_a != RSN_NONE)) begin
      rsn_b_next = RSN_PEER;
    end
  end

  // history update, visible to the round right behind
  always_ff @(posedge clk) begin
    if (rst) begin
      reported_a <= 1'b0;
      reported_b <= 1'b0;
    end else if (s1_adv) begin
      if (rsn_a_next != RSN_NONE) begin
        reported_a <= 1'b1;
      end
      if (rsn_b_next != RSN_NONE) begin
        reported_b <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (rsn_a_next != RSN_NONE)) begin
      last_value_a <= in_temp_a;
      last_tick_a  <= in_tick;
    end
    if (s1_adv && (rsn_b_next != RSN_NONE)) begin
      last_value_b <= in_temp_b;
      last_tick_b  <= in_tick;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsn_a <= rsn_a_next;
      rsn_b <= rsn_b_next;
      // a silent channel shows value zero
      val_a <= (rsn_a_next != RSN_NONE) ? in_temp_a : '0;
      val_b <= (rsn_b_next != RSN_NONE) ? in_temp_b : '0;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_REPA_BIT]              = (rsn_a != RSN_NONE);
    m_tdata[OUT_RSNA_LSB +: 3]         = rsn_a;
    m_tdata[OUT_VALA_LSB +: TEMP_W]    = val_a;
    m_tdata[OUT_REPB_BIT]              = (rsn_b != RSN_NONE);
    m_tdata[OUT_RSNB_LSB +: 3]         = rsn_b;
    m_tdata[OUT_VALB_LSB +: TEMP_W]    = val_b;
  end

  // apb register file: bit 2 of the address picks the register
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_threshold <= THR_RESET;
      heartbeat_ticks <= HB_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_THRESHOLD: delta_threshold <= pwdata[THR_W-1:0];
        REG_HEARTBEAT: heartbeat_ticks <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = {{(APB_DATA_W-THR_W){1'b0}}, delta_threshold};
      REG_HEARTBEAT: prdata = heartbeat_ticks;
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- src/dsr_checker.sv -----
// port-level checks for the dual sensor report-on-change block, bound to the top
// depends on dsr_pkg and dual_sensor_report_on_change_assert.svh
`include "dual_sensor_report_on_change_assert.svh"

module dsr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dsr_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import dsr_pkg::*;

  logic    rep_a;
  logic    rep_b;
  reason_t rsn_a;
  reason_t rsn_b;

  assign rep_a = m_tdata[OUT_REPA_BIT];
  assign rep_b = m_tdata[OUT_REPB_BIT];
  assign rsn_a = reason_t'(m_tdata[OUT_RSNA_LSB +: 3]);
  assign rsn_b = reason_t'(m_tdata[OUT_RSNB_LSB +: 3]);

  // a stalled result holds
  `DSR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

  // report flags agree with the reasons
  `DSR_ASSERT_NOW(a_flag_match, m_tvalid, (rep_a == (rsn_a != RSN_NONE)) && (rep_b == (rsn_b != RSN_NONE)), "report flag and reason disagree")

  // silent channels carry a zero value
  `DSR_ASSERT_NOW(a_silent_zero, m_tvalid, (rep_a || (m_tdata[OUT_VALA_LSB +: TEMP_W] == '0)) && (rep_b || (m_tdata[OUT_VALB_LSB +: TEMP_W] == '0)), "silent channel with nonzero value")

  // peer sync needs the other channel to have a reason of its own
  `DSR_ASSERT_NOW(a_peer_cause, m_tvalid && ((rsn_a == RSN_PEER) || (rsn_b == RSN_PEER)), (rsn_a != RSN_NONE) && (rsn_b != RSN_NONE) && !((rsn_a == RSN_PEER) && (rsn_b == RSN_PEER)), "peer sync without a cause")

endmodule

bind dual_sensor_report_on_change dsr_checker u_dsr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
